// File: hw/rtl/qmn_pkg.sv
`default_nettype none
package qmn_pkg;

    localparam int CompW     = 16;              // Q2.14 component
    localparam int ProdW     = 2 * CompW;       // one partial product, Q4.28
    localparam int SumW      = ProdW + 2;       // sum of four partial products
    localparam int FracQ     = 14;
    localparam int CW        = SumW - FracQ;    // rounded, unsaturated component
    localparam int AbsW      = CW - 1;          // magnitude of a rounded component
    localparam int SqW       = 2 * AbsW - 1;    // square of a rounded component
    localparam int MagW      = SqW + 2;         // sum of four squares, Q11.28
    localparam int RadShift  = 20;              // length comes out in Q.24
    localparam int RootW     = (MagW + RadShift + 1) / 2;
    localparam int FracR     = 24;
    localparam int NumW      = AbsW + FracR;
    localparam int QW        = 16;              // renormalized quotient
    localparam int TolW      = 29;
    localparam int OneShift  = 28;
    localparam int RoundBias = 1 << (FracQ - 1);

    localparam logic [TolW-1:0]         TolReset = TolW'(26844);
    localparam logic signed [CompW-1:0] OneQ14   = CompW'(16384);

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_IDENT,
        MODE_RENORM
    } t_mode;

    typedef struct packed {
        logic                    func;
        logic signed [CompW-1:0] left_x;
        logic signed [CompW-1:0] left_y;
        logic signed [CompW-1:0] left_z;
        logic signed [CompW-1:0] left_w;
        logic signed [CompW-1:0] right_x;
        logic signed [CompW-1:0] right_y;
        logic signed [CompW-1:0] right_z;
        logic signed [CompW-1:0] right_w;
    } t_in_beat;

    typedef struct packed {
        logic signed [CompW-1:0] result_x;
        logic signed [CompW-1:0] result_y;
        logic signed [CompW-1:0] result_z;
        logic signed [CompW-1:0] result_w;
        logic                    not_normalizable;
    } t_out_beat;

    // rounded product components travel with the item through the root and divide
    typedef struct packed {
        t_mode               mode;
        logic [3:0][CW-1:0]  c;
    } t_side;

    function automatic logic signed [CompW-1:0] sat_q14(input logic signed [CW-1:0] v);
        logic signed [CompW-1:0] r;
        if (v > $signed(CW'(32767))) begin
            r = CompW'(32767);
        end else if (v < -$signed(CW'(32768))) begin
            r = CompW'(32768);
        end else begin
            r = v[CompW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/qmn_product.sv
`default_nettype none
module qmn_product (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  qmn_pkg::t_in_beat                i_data,
    output logic                             o_valid,
    output logic                             o_func,
    output logic [3:0][qmn_pkg::CW-1:0]      o_c,
    output logic [qmn_pkg::MagW-1:0]         o_mag
);
    import qmn_pkg::*;

    logic signed [CompW-1:0] a [4];
    logic signed [CompW-1:0] b [4];
    logic signed [ProdW-1:0] n_p  [4][4];
    logic signed [ProdW-1:0] r1_p [4][4];
    logic                    r1_valid, r1_func;

    logic signed [SumW-1:0]  s   [4];
    logic signed [SumW-1:0]  rnd [4];
    logic [3:0][CW-1:0]      n_c, r2_c;
    logic                    r2_valid, r2_func;

    logic signed [2*CW-1:0]  sq_full [4];
    logic [SqW-1:0]          r3_sq [4];
    logic [3:0][CW-1:0]      r3_c;
    logic                    r3_valid, r3_func;

    logic [MagW-1:0]         n_mag, r4_mag;
    logic [3:0][CW-1:0]      r4_c;
    logic                    r4_valid, r4_func;

    assign a[0] = i_data.left_x;
    assign a[1] = i_data.left_y;
    assign a[2] = i_data.left_z;
    assign a[3] = i_data.left_w;
    assign b[0] = i_data.right_x;
    assign b[1] = i_data.right_y;
    assign b[2] = i_data.right_z;
    assign b[3] = i_data.right_w;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_p[i][j] = a[i] * b[j];
            end
        end
    end

    // Hamilton product, w is the scalar part
    always_comb begin
        s[0] = r1_p[3][0] + r1_p[0][3] + r1_p[1][2] - r1_p[2][1];
        s[1] = r1_p[3][1] - r1_p[0][2] + r1_p[1][3] + r1_p[2][0];
        s[2] = r1_p[3][2] + r1_p[0][1] - r1_p[1][0] + r1_p[2][3];
        s[3] = r1_p[3][3] - r1_p[0][0] - r1_p[1][1] - r1_p[2][2];
        for (int i = 0; i < 4; i++) begin
            rnd[i] = s[i] + $signed(SumW'(RoundBias));
            n_c[i] = rnd[i][SumW-1:FracQ];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sq_full[i] = $signed(r2_c[i]) * $signed(r2_c[i]);
        end
        n_mag = MagW'(r3_sq[0]) + MagW'(r3_sq[1]) + MagW'(r3_sq[2]) + MagW'(r3_sq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= n_p;
            r1_func <= i_data.func;
            r2_c    <= n_c;
            r2_func <= r1_func;
            for (int i = 0; i < 4; i++) begin
                r3_sq[i] <= sq_full[i][SqW-1:0];
            end
            r3_c    <= r2_c;
            r3_func <= r2_func;
            r4_mag  <= n_mag;
            r4_c    <= r3_c;
            r4_func <= r3_func;
        end
    end

    assign o_valid = r4_valid;
    assign o_func  = r4_func;
    assign o_c     = r4_c;
    assign o_mag   = r4_mag;

endmodule
`default_nettype wire

// File: hw/rtl/qmn_sqrt.sv
`default_nettype none
module qmn_sqrt #(
    parameter int SideW = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [2*qmn_pkg::RootW-1:0]   i_rad,
    input  logic [SideW-1:0]              i_side,
    output logic                          o_valid,
    output logic [qmn_pkg::RootW-1:0]     o_root,
    output logic [SideW-1:0]              o_side
);
    import qmn_pkg::*;

    // one result bit per stage, restoring method
    logic [RootW-1:0]   r_rem  [RootW];
    logic [RootW-1:0]   r_res  [RootW];
    logic [2*RootW-1:0] r_rad  [RootW];
    logic [SideW-1:0]   r_side [RootW];
    logic [RootW-1:0]   r_valid;

    logic [RootW-1:0]   n_rem  [RootW];
    logic [RootW-1:0]   n_res  [RootW];
    logic [2*RootW-1:0] n_rad  [RootW];
    logic [SideW-1:0]   n_side [RootW];
    logic [RootW-1:0]   n_valid;

    always_comb begin
        logic [RootW-1:0]   rem_in;
        logic [RootW-1:0]   res_in;
        logic [2*RootW-1:0] rad_in;
        logic [RootW+1:0]   rem_sh;
        logic [RootW+1:0]   trial;
        for (int k = 0; k < RootW; k++) begin
            if (k == 0) begin
                rem_in     = '0;
                res_in     = '0;
                rad_in     = i_rad;
                n_side[k]  = i_side;
                n_valid[k] = i_valid;
            end else begin
                rem_in     = r_rem[k-1];
                res_in     = r_res[k-1];
                rad_in     = r_rad[k-1];
                n_side[k]  = r_side[k-1];
                n_valid[k] = r_valid[k-1];
            end
            rem_sh = {rem_in, rad_in[2*RootW-1 -: 2]};
            trial  = {res_in, 2'b01};
            if (rem_sh >= trial) begin
                n_rem[k] = RootW'(rem_sh - trial);
                n_res[k] = {res_in[RootW-2:0], 1'b1};
            end else begin
                n_rem[k] = rem_sh[RootW-1:0];
                n_res[k] = {res_in[RootW-2:0], 1'b0};
            end
            n_rad[k] = {rad_in[2*RootW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_res  <= n_res;
            r_rad  <= n_rad;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid[RootW-1];
    assign o_root  = r_res[RootW-1];
    assign o_side  = r_side[RootW-1];

endmodule
`default_nettype wire

// File: hw/rtl/qmn_divide.sv
`default_nettype none
module qmn_divide #(
    parameter int SideW = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [3:0][qmn_pkg::AbsW-1:0]     i_abs,
    input  logic [qmn_pkg::RootW-1:0]         i_root,
    input  logic [SideW-1:0]                  i_side,
    output logic                              o_valid,
    output logic [3:0][qmn_pkg::QW-1:0]       o_quot,
    output logic [SideW-1:0]                  o_side
);
    import qmn_pkg::*;

    localparam int RemW   = RootW + 1;
    localparam int Stages = QW + 1;

    // stage 0 loads the rounded numerator, then one quotient bit per stage on four lanes
    logic [3:0][RemW-1:0] r_rem  [Stages];
    logic [3:0][QW-1:0]   r_low  [Stages];
    logic [3:0][QW-1:0]   r_quot [Stages];
    logic [RootW-1:0]     r_div  [Stages];
    logic [SideW-1:0]     r_side [Stages];
    logic [Stages-1:0]    r_valid;

    logic [3:0][RemW-1:0] n_rem  [Stages];
    logic [3:0][QW-1:0]   n_low  [Stages];
    logic [3:0][QW-1:0]   n_quot [Stages];
    logic [RootW-1:0]     n_div  [Stages];
    logic [SideW-1:0]     n_side [Stages];
    logic [Stages-1:0]    n_valid;

    always_comb begin
        logic [NumW-1:0] num;
        logic [RemW-1:0] rsh;
        for (int s = 0; s < Stages; s++) begin
            if (s == 0) begin
                for (int l = 0; l < 4; l++) begin
                    num         = NumW'({i_abs[l], {FracR{1'b0}}}) + NumW'(i_root[RootW-1:1]);
                    n_rem[s][l] = RemW'(num[NumW-1:QW]);
                    n_low[s][l] = num[QW-1:0];
                    n_quot[s][l] = '0;
                end
                n_div[s]   = i_root;
                n_side[s]  = i_side;
                n_valid[s] = i_valid;
            end else begin
                for (int l = 0; l < 4; l++) begin
                    rsh = {r_rem[s-1][l][RemW-2:0], r_low[s-1][l][QW-1]};
                    if (rsh >= {1'b0, r_div[s-1]}) begin
                        n_rem[s][l]  = rsh - {1'b0, r_div[s-1]};
                        n_quot[s][l] = {r_quot[s-1][l][QW-2:0], 1'b1};
                    end else begin
                        n_rem[s][l]  = rsh;
                        n_quot[s][l] = {r_quot[s-1][l][QW-2:0], 1'b0};
                    end
                    n_low[s][l] = {r_low[s-1][l][QW-2:0], 1'b0};
                end
                n_div[s]   = r_div[s-1];
                n_side[s]  = r_side[s-1];
                n_valid[s] = r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_low  <= n_low;
            r_quot <= n_quot;
            r_div  <= n_div;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid[Stages-1];
    assign o_quot  = r_quot[Stages-1];
    assign o_side  = r_side[Stages-1];

endmodule
`default_nettype wire

// File: hw/rtl/quaternion_multiply_normalize_unit.sv
// Quaternion multiply and renormalize. Takes one pair of Q2.14 quaternions per cycle
// while the skid register is empty and returns one result per pair, in order. Most of
// the path is the square root, which resolves one bit of the 30-bit length per stage,
// followed by a 17-stage divider that forms the four renormalized components in
// parallel; the Hamilton product itself takes four stages. Every item runs the full
// path whether or not it is renormalized. A stall at the output freezes the pipeline
// after one extra item has moved into the skid register.
// magnitude_tolerance lives at byte address 0 of the APB port and should be written
// only while no item is in flight.
`default_nettype none
module quaternion_multiply_normalize_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  qmn_pkg::t_in_beat      i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output qmn_pkg::t_out_beat     o_out_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import qmn_pkg::*;

    localparam logic [1:0] AddrTol = 2'd0;
    localparam int         SideW   = $bits(t_side);

    logic [TolW-1:0] r_tol;

    logic               en;
    logic               prod_valid, prod_func;
    logic [3:0][CW-1:0] prod_c;
    logic [MagW-1:0]    prod_mag;

    logic               deg, near_hi, near_lo;
    t_side              n5_side, r5_side;
    logic [2*RootW-1:0] n5_rad, r5_rad;
    logic               r5_valid;

    logic               sq_valid;
    logic [RootW-1:0]   sq_root;
    logic [SideW-1:0]   sq_side_v;
    t_side              sq_side;
    logic [3:0][AbsW-1:0] div_abs;

    logic               dv_valid;
    logic [3:0][QW-1:0] dv_quot;
    logic [SideW-1:0]   dv_side_v;
    t_side              fs;
    t_out_beat          d_out;

    logic               r_out_valid, r_skid_valid;
    t_out_beat          r_out_data, r_skid_data;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TolReset;
        end else if (psel && penable && pwrite && pready && paddr == AddrTol) begin
            r_tol <= pwdata[TolW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == AddrTol) ? 32'(r_tol) : '0;

    // the whole pipeline advances while the skid register is free
    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    qmn_product u_product (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (prod_valid),
        .o_func  (prod_func),
        .o_c     (prod_c),
        .o_mag   (prod_mag)
    );

    // classify against the tolerance
    always_comb begin
        deg     = (prod_mag == '0) || (prod_mag < MagW'(r_tol));
        near_hi = (MagW+1)'(prod_mag) <= ((MagW+1)'(1) << OneShift) + (MagW+1)'(r_tol);
        near_lo = (MagW+1)'(prod_mag) + (MagW+1)'(r_tol) >= ((MagW+1)'(1) << OneShift);
        n5_side.c = prod_c;
        if (prod_func) begin
            n5_side.mode = MODE_PASS;
        end else if (deg) begin
            n5_side.mode = MODE_IDENT;
        end else if (near_hi && near_lo) begin
            n5_side.mode = MODE_PASS;
        end else begin
            n5_side.mode = MODE_RENORM;
        end
        n5_rad = (2*RootW)'({prod_mag, {RadShift{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_side <= n5_side;
            r5_rad  <= n5_rad;
        end
    end

    qmn_sqrt #(.SideW(SideW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_valid),
        .i_rad   (r5_rad),
        .i_side  (r5_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side_v)
    );

    assign sq_side = t_side'(sq_side_v);

    always_comb begin
        logic signed [CW-1:0] cv;
        logic signed [CW-1:0] av;
        for (int l = 0; l < 4; l++) begin
            cv = $signed(sq_side.c[l]);
            av = cv[CW-1] ? -cv : cv;
            div_abs[l] = av[AbsW-1:0];
        end
    end

    qmn_divide #(.SideW(SideW)) u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_abs   (div_abs),
        .i_root  (sq_root),
        .i_side  (sq_side_v),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_side_v)
    );

    assign fs = t_side'(dv_side_v);

    always_comb begin
        logic                    flip;
        logic signed [CW-1:0]    qv;
        logic signed [CompW-1:0] res [4];
        logic                    flag;
        flip = fs.c[3][CW-1];
        flag = 1'b0;
        for (int l = 0; l < 4; l++) begin
            res[l] = sat_q14($signed(fs.c[l]));
        end
        case (fs.mode)
            MODE_PASS: begin
                flag = 1'b0;
            end
            MODE_IDENT: begin
                res[0] = '0;
                res[1] = '0;
                res[2] = '0;
                res[3] = OneQ14;
                flag   = 1'b1;
            end
            MODE_RENORM: begin
                for (int l = 0; l < 4; l++) begin
                    qv = $signed(CW'(dv_quot[l]));
                    // sign follows the component, flipped so that w ends non-negative
                    if (fs.c[l][CW-1] ^ flip) begin
                        qv = -qv;
                    end
                    res[l] = sat_q14(qv);
                end
            end
            default: begin
                flag = 1'b0;
            end
        endcase
        d_out.result_x         = res[0];
        d_out.result_y         = res[1];
        d_out.result_z         = res[2];
        d_out.result_w         = res[3];
        d_out.not_normalizable = flag;
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= dv_valid;
        end else if (dv_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_valid || i_out_ready) begin
            r_out_data <= d_out;
        end else begin
            r_skid_data <= d_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// File: hw/rtl/qmn_checker.sv
`default_nettype none
module qmn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input qmn_pkg::t_out_beat o_out_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [1:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);
    import qmn_pkg::*;

    localparam logic [1:0] AddrTol = 2'd0;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.not_normalizable |->
            o_out_data.result_x == '0 && o_out_data.result_y == '0 &&
            o_out_data.result_z == '0 && o_out_data.result_w == OneQ14)
        else $error("flagged beat is not the identity");

    a_renorm_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.not_normalizable |-> !o_out_data.result_w[CompW-1])
        else $error("identity beat has negative w");

    a_cfg_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr == AddrTol ##1 paddr == AddrTol |->
            prdata[TolW-1:0] == $past(pwdata[TolW-1:0]) && prdata[31:TolW] == '0)
        else $error("tolerance readback mismatch");

endmodule

bind quaternion_multiply_normalize_unit qmn_checker u_qmn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);
`default_nettype wire

// File: tb/tb_quaternion_multiply_normalize_unit.sv
`timescale 1ns / 1ps
module tb_quaternion_multiply_normalize_unit;
    import qmn_pkg::*;

    localparam int LatencyCycles = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_beat    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_beat   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    quaternion_multiply_normalize_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    logic [TolW-1:0] tolerance_q28;
    t_out_beat       expected_products[$];
    int              error_count = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              hold_off_cycles = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic longint round_to_q14(input longint p);
        return (p + 8192) >>> 14;
    endfunction

    function automatic longint clamp_q14(input longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_out_beat predict_product(input t_in_beat q);
        longint ax, ay, az, aw, bx, by, bz, bw, tol, mag;
        longint c[4];
        longint r[4];
        longint unsigned root, a, quo;
        logic flip, neg, flag;
        t_out_beat o;
        ax = q.left_x;  ay = q.left_y;  az = q.left_z;  aw = q.left_w;
        bx = q.right_x; by = q.right_y; bz = q.right_z; bw = q.right_w;
        c[0] = round_to_q14(aw * bx + ax * bw + ay * bz - az * by);
        c[1] = round_to_q14(aw * by - ax * bz + ay * bw + az * bx);
        c[2] = round_to_q14(aw * bz + ax * by - ay * bx + az * bw);
        c[3] = round_to_q14(aw * bw - ax * bx - ay * by - az * bz);
        flag = 1'b0;
        for (int i = 0; i < 4; i++) r[i] = clamp_q14(c[i]);
        if (q.func == 1'b0) begin
            tol = longint'(tolerance_q28);
            mag = 0;
            for (int i = 0; i < 4; i++) mag += c[i] * c[i];
            if (mag == 0 || mag < tol) begin
                r[0] = 0; r[1] = 0; r[2] = 0; r[3] = 16384;
                flag = 1'b1;
            end else if (mag > (64'sd1 << 28) + tol || mag < (64'sd1 << 28) - tol) begin
                root = int_sqrt(longint'(mag) << 20);
                flip = c[3] < 0;
                for (int i = 0; i < 4; i++) begin
                    neg = c[i] < 0;
                    a = neg ? -c[i] : c[i];
                    quo = ((a << 24) + (root >> 1)) / root;
                    r[i] = clamp_q14((neg != flip) ? -longint'(quo) : longint'(quo));
                end
            end
        end
        o.result_x = r[0][15:0];
        o.result_y = r[1][15:0];
        o.result_z = r[2][15:0];
        o.result_w = r[3][15:0];
        o.not_normalizable = flag;
        return o;
    endfunction

    // receive side: stall randomly or for a counted hold-off, check each beat
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_products.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                want = expected_products.pop_front();
                if (o_out_data.result_x !== want.result_x)
                    report_mismatch("result_x", o_out_data.result_x, want.result_x);
                if (o_out_data.result_y !== want.result_y)
                    report_mismatch("result_y", o_out_data.result_y, want.result_y);
                if (o_out_data.result_z !== want.result_z)
                    report_mismatch("result_z", o_out_data.result_z, want.result_z);
                if (o_out_data.result_w !== want.result_w)
                    report_mismatch("result_w", o_out_data.result_w, want.result_w);
                if (o_out_data.not_normalizable !== want.not_normalizable)
                    report_mismatch("not_normalizable", o_out_data.not_normalizable,
                                    want.not_normalizable);
            end
        end
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_tolerance(input logic [31:0] value);
        i_in_valid <= 1'b0;
        // drain: every item gives a beat
        while (expected_products.size() != 0) @(posedge i_clk);
        repeat (LatencyCycles) @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        tolerance_q28 = value[TolW-1:0];
    endtask

    // valid stays up after a beat until the next beat or an idle cycle replaces it
    task automatic send_pair(input t_in_beat q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= q;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_products.push_back(predict_product(q));
    endtask

    function automatic t_in_beat make_pair(input logic f, input int lx, ly, lz, lw,
                                           input int rx, ry, rz, rw);
        t_in_beat q;
        q.func = f;
        q.left_x = lx[15:0];  q.left_y = ly[15:0];  q.left_z = lz[15:0];  q.left_w = lw[15:0];
        q.right_x = rx[15:0]; q.right_y = ry[15:0]; q.right_z = rz[15:0]; q.right_w = rw[15:0];
        return q;
    endfunction

    // half with components within +-0.5, a quarter tiny, a quarter full range
    function automatic int rand_comp(input int kind);
        case (kind)
            0: return $signed($urandom_range(65535)) - 32768;
            1: return $signed($urandom_range(64)) - 32;
            default: return $signed($urandom_range(16384)) - 8192;
        endcase
    endfunction

    function automatic t_in_beat rand_pair();
        int kl, kr;
        kl = $urandom_range(3);
        kr = $urandom_range(3);
        return make_pair($urandom_range(3) == 0,
                         rand_comp(kl), rand_comp(kl), rand_comp(kl), rand_comp(kl),
                         rand_comp(kr), rand_comp(kr), rand_comp(kr), rand_comp(kr));
    endfunction

    task automatic test_directed();
        for (int f = 0; f < 2; f++) begin
            send_pair(make_pair(f, 0, 0, 0, 16384, 0, 0, 0, 16384));
            send_pair(make_pair(f, 0, 0, 0, 0, 1, 2, 3, 4));
            send_pair(make_pair(f, 1, 0, 0, 0, 1, 0, 0, 0));
            send_pair(make_pair(f, 2, 3, 1, 2, 1, 1, 2, 3));
            send_pair(make_pair(f, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, -32768));
            send_pair(make_pair(f, 32767, 32767, 32767, 32767,
                                -32768, 32767, -32768, 32767));
            send_pair(make_pair(f, 8192, 8192, 8192, 8192, 8192, -8192, 8192, -8192));
            send_pair(make_pair(f, 16384, 0, 0, 0, 0, 16384, 0, 0));
            send_pair(make_pair(f, 11585, 0, 0, 11585, 0, 11585, 0, -11585));
            send_pair(make_pair(f, 16385, 0, 0, 0, 0, 0, 0, 16384));
            send_pair(make_pair(f, 0, 0, 0, -16000, 0, 0, 0, 16000));
        end
    endtask

    task automatic test_random(input int count);
        repeat (count) send_pair(rand_pair());
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 200;
        repeat (150) send_pair(rand_pair());
        i_in_valid <= 1'b0;
        // let everything drain before going on
        while (expected_products.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        tolerance_q28 = TolReset;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 22; recv_idle_pct = 47;
        test_random(300);
        write_tolerance(32'd0);
        test_directed();
        test_random(150);
        write_tolerance(32'd268435456);
        test_directed();
        test_random(150);
        write_tolerance(32'hFFFF_FFFF);
        test_random(100);
        write_tolerance(32'd2000000);
        send_idle_pct = 47; recv_idle_pct = 22;
        test_random(300);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        write_tolerance(32'd26844);
        test_random(350);
        i_in_valid <= 1'b0;
        while (expected_products.size() != 0) @(posedge i_clk);
        repeat (LatencyCycles) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
